// ----- hw/rtl/lso_pkg.sv -----
// Shared types and constants for the last-occurrence substring search block.
package lso_pkg;

	// Depth of the queue between the front and back parts (a power of two).
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

	// Value of the kind field that marks a pattern byte; the other value marks text.
	localparam logic IN_KIND_PATTERN = 1'b0;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_PATTERN = 2'd1,
		STATUS_TEXT    = 2'd2
	} status_t;

	// One classified input transaction as it travels from the front to the back.
	typedef struct packed {
		logic       is_pattern;
		logic [7:0] value;
		logic       last;
	} op_t;

	typedef struct packed {
		logic                   full;
		logic                   empty;
		logic [QUEUE_LVL_W-1:0] level;
	} queue_stat_t;

endpackage

// ----- hw/rtl/lso_in_if.sv -----
// Input channel: one pattern or text byte per transaction.
interface lso_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] value;
	logic       last;

	modport source (output valid, output kind, output value, output last, input ready);
	modport sink (input valid, input kind, input value, input last, output ready);
endinterface

// ----- hw/rtl/lso_out_if.sv -----
// Output channel: one search result per transaction.
interface lso_out_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [15:0] match_start;
	logic [1:0]  status;

	modport source (output valid, output found, output match_start, output status, input ready);
	modport sink (input valid, input found, input match_start, input status, output ready);
endinterface

// ----- hw/rtl/lso_front.sv -----
// Front part: registers and classifies input transactions for the queue.
module lso_front (
	input  logic          clk,
	input  logic          arst_n,
	lso_in_if.sink        item,
	output logic          fr_valid,
	output lso_pkg::op_t  fr_op,
	input  logic          fr_ready
);
	import lso_pkg::*;

	logic fr_valid_s1;
	op_t  fr_op_s1;
	logic take;

	assign item.ready = !fr_valid_s1 || fr_ready;
	assign take       = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_valid_s1 <= 1'b0;
		end else if (take) begin
			fr_valid_s1 <= 1'b1;
		end else if (fr_ready) begin
			fr_valid_s1 <= 1'b0;
		end
	end

	// Kind zero is a pattern byte; everything else is text.
	always_ff @(posedge clk) begin
		if (take) begin
			fr_op_s1.is_pattern <= (item.kind == IN_KIND_PATTERN);
			fr_op_s1.value      <= item.value;
			fr_op_s1.last       <= item.last;
		end
	end

	assign fr_valid = fr_valid_s1;
	assign fr_op    = fr_op_s1;
endmodule

// ----- hw/rtl/lso_queue.sv -----
// Short register queue that decouples the front and back parts.
module lso_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	input  lso_pkg::op_t        push_op,
	output logic                push_ready,
	output logic                pop_valid,
	output lso_pkg::op_t        pop_op,
	input  logic                pop,
	output lso_pkg::queue_stat_t stat
);
	import lso_pkg::*;

	op_t                    slot_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_LVL_W-1:0] level_q;
	logic                   full;
	logic                   empty;
	logic                   push;
	logic                   do_pop;

	assign full       = (level_q == QUEUE_LVL_W'(QUEUE_DEPTH));
	assign empty      = (level_q == '0);
	assign push_ready = !full;
	assign push       = push_valid && !full;
	assign do_pop     = pop && !empty;
	assign pop_valid  = !empty;
	assign pop_op     = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			if (push && !do_pop) begin
				level_q <= level_q + QUEUE_LVL_W'(1);
			end else if (do_pop && !push) begin
				level_q <= level_q - QUEUE_LVL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_op;
	end

	assign stat.full  = full;
	assign stat.empty = empty;
	assign stat.level = level_q;
endmodule

// ----- hw/rtl/lso_back.sv -----
// Back part: pattern store, text window, parallel compare and result register.
module lso_back #(
	parameter int MAX_PATTERN = 16,
	parameter int MAX_TEXT    = 65536
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         op_valid,
	input  lso_pkg::op_t op,
	output logic         pop,
	lso_out_if.source    result
);
	import lso_pkg::*;

	localparam int LW  = $clog2(MAX_PATTERN + 1);
	localparam int CW  = $clog2(MAX_TEXT + 2);
	localparam int SW  = ((CW > LW) ? CW : LW) + 1;
	localparam int LSW = $clog2(MAX_TEXT);

	// The pattern is held newest byte first, so entry i lines up with window entry i.
	logic [7:0]     pat_q [MAX_PATTERN];
	logic [7:0]     win_q [MAX_PATTERN];
	logic [7:0]     win_next [MAX_PATTERN];
	logic [LW-1:0]  plen_q;
	logic           pcomplete_q;
	logic           povf_q;
	logic [CW-1:0]  tcount_q;
	logic           seen_q;
	logic [LSW-1:0] latest_q;
	logic           res_valid_q;
	logic           found_q;
	logic [15:0]    start_q;
	status_t        status_q;

	logic [LW-1:0]      plen_eff;
	logic               pat_room;
	logic               usable;
	logic               text_room;
	logic [MAX_PATTERN-1:0] eq;
	logic               win_match;
	logic [SW-1:0]      cnt1;
	logic [SW-1:0]      diff;
	logic               hit;
	logic [CW-1:0]      tcount_new;
	logic               seen_new;
	logic [LSW-1:0]     latest_new;
	logic [LSW+15:0]    latest_ext;
	logic               text_op;
	logic               text_end;
	status_t            status_new;

	assign pop      = op_valid && (!res_valid_q || result.ready);
	assign text_op  = pop && !op.is_pattern;
	assign text_end = text_op && op.last;

	assign plen_eff  = pcomplete_q ? '0 : plen_q;
	assign pat_room  = (plen_eff < LW'(MAX_PATTERN));
	assign usable    = pcomplete_q && !povf_q && (plen_q != '0);
	assign text_room = (tcount_q < CW'(MAX_TEXT));

	always_comb begin
		win_next[0] = op.value;
		for (int i = 1; i < MAX_PATTERN; i++) begin
			win_next[i] = win_q[i-1];
		end
		for (int i = 0; i < MAX_PATTERN; i++) begin
			eq[i] = (win_next[i] == pat_q[i]) || (LW'(i) >= plen_q);
		end
	end

	assign win_match = &eq;
	assign cnt1      = SW'(tcount_q) + SW'(1);
	assign diff      = cnt1 - SW'(plen_q);
	assign hit       = text_room && usable && (cnt1 >= SW'(plen_q)) && win_match;

	assign tcount_new = (tcount_q <= CW'(MAX_TEXT)) ? tcount_q + CW'(1) : tcount_q;
	assign seen_new   = seen_q || hit;
	assign latest_new = hit ? diff[LSW-1:0] : latest_q;
	assign latest_ext = {16'b0, latest_new};

	always_comb begin
		if (!usable) begin
			status_new = STATUS_PATTERN;
		end else if (tcount_new > CW'(MAX_TEXT)) begin
			status_new = STATUS_TEXT;
		end else begin
			status_new = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q      <= '0;
			pcomplete_q <= 1'b0;
			povf_q      <= 1'b0;
			tcount_q    <= '0;
			seen_q      <= 1'b0;
			latest_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (text_end) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (pop && op.is_pattern) begin
				tcount_q    <= '0;
				seen_q      <= 1'b0;
				latest_q    <= '0;
				pcomplete_q <= op.last;
				if (pat_room) begin
					plen_q <= plen_eff + LW'(1);
					povf_q <= pcomplete_q ? 1'b0 : povf_q;
				end else begin
					plen_q <= plen_eff;
					povf_q <= 1'b1;
				end
			end else if (text_end) begin
				tcount_q <= '0;
				seen_q   <= 1'b0;
				latest_q <= '0;
			end else if (text_op) begin
				tcount_q <= tcount_new;
				seen_q   <= seen_new;
				latest_q <= latest_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && op.is_pattern && pat_room) begin
			pat_q[0] <= op.value;
			for (int i = 1; i < MAX_PATTERN; i++) begin
				pat_q[i] <= pat_q[i-1];
			end
		end
		if (text_op && text_room) begin
			for (int i = 0; i < MAX_PATTERN; i++) begin
				win_q[i] <= win_next[i];
			end
		end
		if (text_end) begin
			status_q <= status_new;
			found_q  <= (status_new == STATUS_OK) && seen_new;
			start_q  <= ((status_new == STATUS_OK) && seen_new) ? latest_ext[15:0] : 16'b0;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.found       = found_q;
	assign result.match_start = start_q;
	assign result.status      = status_q;
endmodule

// ----- hw/rtl/last_substring_occurrence.sv -----
// Throughput: one transaction per cycle on the input, with no gaps while the result sink keeps up.
// Result path: a closing text byte is captured in the front register when accepted, then written
// to a queue slot, then compared and captured in the result register, which raises result valid.
// The back part's combinational window compare against all pattern bytes sets the pace.
// Reset (arst_n low) empties the queue, forgets the pattern and drops any text in progress;
// pattern and window bytes themselves are not cleared and need not be.
module last_substring_occurrence #(
	parameter int MAX_PATTERN = 16,
	parameter int MAX_TEXT    = 65536
) (
	input  logic      clk,
	input  logic      arst_n,
	lso_in_if.sink    item,
	lso_out_if.source result
);
	import lso_pkg::*;

	// Front to queue: a registered, classified transaction.
	logic        fr_valid;
	op_t         fr_op;
	logic        fr_ready;

	// Queue to back: the oldest waiting transaction and its pop strobe.
	logic        q_valid;
	op_t         q_op;
	logic        q_pop;
	queue_stat_t q_stat;

	// The front takes a byte whenever its register is empty or moving into the queue,
	// so the input never waits on the result channel until the queue fills up.
	lso_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.fr_valid (fr_valid),
		.fr_op    (fr_op),
		.fr_ready (fr_ready)
	);

	// The queue absorbs short stalls on the result side.
	lso_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_op    (fr_op),
		.push_ready (fr_ready),
		.pop_valid  (q_valid),
		.pop_op     (q_op),
		.pop        (q_pop),
		.stat       (q_stat)
	);

	// The back part consumes one transaction per cycle unless a finished result is
	// still held in its output register and the sink is not taking it.
	lso_back #(
		.MAX_PATTERN (MAX_PATTERN),
		.MAX_TEXT    (MAX_TEXT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (q_valid),
		.op       (q_op),
		.pop      (q_pop),
		.result   (result)
	);

`ifndef SYNTHESIS
	a_queue_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty) && (q_stat.level <= QUEUE_LVL_W'(QUEUE_DEPTH)))
		else $error("queue level and flags disagree");

	a_front_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> fr_valid)
		else $error("accepted transaction did not reach the front register");

	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("back part popped an empty queue");

	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.found) |-> (result.match_start == 16'b0))
		else $error("match start nonzero without a match");
`endif
endmodule

// ----- tb/lso_tb_pkg.sv -----
// Codes shared by the checker and the stimulus of the substring search testbench.
package lso_tb_pkg;

	typedef enum logic {
		KIND_PATTERN = 1'b0,
		KIND_TEXT    = 1'b1
	} kind_t;

endpackage

// ----- tb/lso_search_checker.sv -----
// Watches both channels of the substring search block, predicts each result and compares it.
module lso_search_checker #(
	parameter int MAX_PATTERN = 16,
	parameter int MAX_TEXT    = 65536
) (
	input  logic clk,
	input  logic arst_n,
	lso_in_if    item,
	lso_out_if   result,
	output int   fail_count,
	output int   pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import lso_pkg::*;
	import lso_tb_pkg::*;

	typedef struct packed {
		logic        found;
		logic [15:0] match_start;
		status_t     status;
	} search_result_t;

	search_result_t expected_results[$];

	logic [7:0]  pat_bytes[MAX_PATTERN];
	int unsigned pat_len;
	bit          pat_done;
	bit          pat_over;
	logic [7:0]  win[MAX_PATTERN];
	int unsigned txt_count;
	bit          hit_seen;
	int unsigned hit_start;
	int          failures;
	int          waiting;

	assign fail_count    = failures;
	assign pending_count = waiting;

	function automatic void drop_text();
		foreach (win[i]) win[i] = 8'h00;
		txt_count = 0;
		hit_seen  = 1'b0;
		hit_start = 0;
	endfunction

	function automatic bit pattern_ready();
		return pat_done && !pat_over && pat_len > 0;
	endfunction

	// The window holds the newest byte at index 0, so it runs against the pattern backward.
	function automatic bit window_hit();
		for (int i = 0; i < pat_len; i++) begin
			if (win[i] != pat_bytes[pat_len - 1 - i])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void predict_search(logic k, logic [7:0] v, logic l);
		search_result_t r;
		if (k == KIND_PATTERN) begin
			drop_text();
			if (pat_done) begin
				pat_len  = 0;
				pat_over = 1'b0;
				pat_done = 1'b0;
			end
			if (pat_len < MAX_PATTERN) begin
				pat_bytes[pat_len] = v;
				pat_len++;
			end else begin
				pat_over = 1'b1;
			end
			if (l)
				pat_done = 1'b1;
			return;
		end
		if (txt_count < MAX_TEXT) begin
			for (int i = MAX_PATTERN - 1; i > 0; i--)
				win[i] = win[i - 1];
			win[0] = v;
			if (pattern_ready() && txt_count + 1 >= pat_len && window_hit()) begin
				hit_seen  = 1'b1;
				hit_start = txt_count + 1 - pat_len;
			end
		end
		if (txt_count <= MAX_TEXT)
			txt_count++;
		if (!l)
			return;
		r.found       = 1'b0;
		r.match_start = '0;
		r.status      = STATUS_OK;
		if (!pattern_ready()) begin
			r.status = STATUS_PATTERN;
		end else if (txt_count > MAX_TEXT) begin
			r.status = STATUS_TEXT;
		end else if (hit_seen) begin
			r.found       = 1'b1;
			r.match_start = hit_start[15:0];
		end
		expected_results.push_back(r);
		drop_text();
	endfunction

	function automatic void check_result();
		search_result_t want;
		if (expected_results.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("unexpected result: found %0d start %0d status %0d",
					result.found, result.match_start, result.status);
			return;
		end
		want = expected_results.pop_front();
		if (result.found !== want.found || result.match_start !== want.match_start ||
				result.status !== want.status) begin
			failures++;
			if (failures <= 10)
				$display("result mismatch: expected found %0d start %0d status %0d, got found %0d start %0d status %0d",
					want.found, want.match_start, want.status,
					result.found, result.match_start, result.status);
		end
	endfunction

	initial begin
		failures = 0;
		waiting  = 0;
	end

	// The output side is handled first, since a result never belongs to a byte taken at the
	// same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (pat_bytes[i]) pat_bytes[i] = 8'h00;
			pat_len  = 0;
			pat_done = 1'b0;
			pat_over = 1'b0;
			drop_text();
			expected_results.delete();
		end else begin
			if (result.valid && result.ready)
				check_result();
			if (item.valid && item.ready)
				predict_search(item.kind, item.value, item.last);
		end
		waiting = expected_results.size();
	end

endmodule

// ----- tb/testbench.sv -----
// Top of the substring search testbench: clock, reset, stimulus, receiver stalls and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lso_tb_pkg::*;

	localparam int PATTERN_LIMIT = 16;
	localparam int TEXT_LIMIT    = 65536;
	localparam int RANDOM_ITEMS  = 2000;

	logic clk;
	logic arst_n;
	int   chk_fails;
	int   chk_pending;

	// Percentages of cycles in which the sender holds back or the receiver refuses a result.
	int src_idle_pct;
	int sink_stall_pct;
	int bytes_sent;

	// Bytes of the most recent pattern, kept so that random texts can carry copies of it.
	logic [7:0] loaded_pattern[$];

	lso_in_if  item_ch();
	lso_out_if result_ch();

	last_substring_occurrence #(
		.MAX_PATTERN(PATTERN_LIMIT),
		.MAX_TEXT   (TEXT_LIMIT)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(result_ch)
	);

	lso_search_checker #(
		.MAX_PATTERN(PATTERN_LIMIT),
		.MAX_TEXT   (TEXT_LIMIT)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item_ch),
		.result       (result_ch),
		.fail_count   (chk_fails),
		.pending_count(chk_pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case a result never arrives or the handshake hangs.
	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	// The receiver decides afresh at every edge whether it takes a result, so that stalls land
	// on every phase of the block's pipeline.
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			result_ch.ready <= ($urandom_range(99, 0) >= sink_stall_pct);
		end
	end

	// Presents one byte and returns once the transaction has been accepted. Valid stays high
	// afterward, so back-to-back bytes never drop it between transactions.
	task automatic push_byte(input kind_t k, input logic [7:0] v, input logic l);
		while ($urandom_range(99, 0) < src_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.kind  <= k;
		item_ch.value <= v;
		item_ch.last  <= l;
		do @(posedge clk); while (!item_ch.ready);
		bytes_sent++;
	endtask

	// Holds the sender back until every outstanding result has come out, then switches pace.
	// The extra edge lets the checker register the last accepted byte first.
	task automatic drain_and_pace(input int src_pct, input int sink_pct);
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (chk_pending != 0) @(posedge clk);
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
	endtask

	// A narrow alphabet of two bytes makes matches frequent; the wide one covers all values.
	function automatic logic [7:0] pick_byte(bit narrow, logic [7:0] base, logic [7:0] flip);
		if (!narrow)
			return 8'($urandom_range(255, 0));
		return $urandom_range(1, 0) ? base : base ^ flip;
	endfunction

	// One random search session: usually a fresh pattern followed by a few texts, sometimes an
	// overlong or unfinished pattern, sometimes the old pattern kept, and now and then a text
	// cut off by a stray pattern byte.
	task automatic random_session();
		logic [7:0] txt[$];
		logic [7:0] b;
		logic [7:0] base;
		logic [7:0] flip;
		bit         narrow;
		bit         open_end;
		bit         keep_old;
		int         sel;
		int         plen;
		int         tlen;
		int         pos;
		int         ntexts;
		narrow   = 1'($urandom_range(1, 0));
		base     = 8'($urandom_range(255, 0));
		flip     = 8'd1 << $urandom_range(7, 0);
		sel      = $urandom_range(99, 0);
		keep_old = (sel >= 95) && (loaded_pattern.size() != 0);
		open_end = (sel >= 90) && (sel < 95);
		if (sel < 60)
			plen = $urandom_range(4, 1);
		else if (sel < 84)
			plen = $urandom_range(PATTERN_LIMIT, 1);
		else if (sel < 90)
			plen = $urandom_range(PATTERN_LIMIT + 4, PATTERN_LIMIT + 1);
		else
			plen = $urandom_range(6, 1);
		if (!keep_old) begin
			loaded_pattern.delete();
			for (int i = 0; i < plen; i++) begin
				b = pick_byte(narrow, base, flip);
				loaded_pattern.push_back(b);
				push_byte(KIND_PATTERN, b, (i == plen - 1) && !open_end);
			end
		end
		ntexts = $urandom_range(4, 1);
		repeat (ntexts) begin
			if ($urandom_range(99, 0) < 70)
				tlen = $urandom_range(24, 1);
			else
				tlen = $urandom_range(80, 1);
			txt.delete();
			for (int i = 0; i < tlen; i++)
				txt.push_back(pick_byte(narrow, base, flip));
			// Plant copies of the pattern so that wide alphabets also see matches.
			if (loaded_pattern.size() <= tlen) begin
				repeat ($urandom_range(2, 0)) begin
					pos = $urandom_range(tlen - loaded_pattern.size(), 0);
					foreach (loaded_pattern[j])
						txt[pos + j] = loaded_pattern[j];
				end
			end
			for (int i = 0; i < tlen; i++) begin
				if (i > 0 && $urandom_range(99, 0) == 0) begin
					// A pattern byte in the middle of a text throws the text away.
					b = 8'($urandom_range(255, 0));
					push_byte(KIND_PATTERN, b, 1'b1);
					loaded_pattern.delete();
					loaded_pattern.push_back(b);
					break;
				end
				push_byte(KIND_TEXT, txt[i], i == tlen - 1);
			end
		end
	endtask

	initial begin
		logic [7:0] pat16[$];
		arst_n          <= 1'b0;
		item_ch.valid   <= 1'b0;
		item_ch.kind    <= KIND_PATTERN;
		item_ch.value   <= 8'h00;
		item_ch.last    <= 1'b0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		bytes_sent     = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cases. A text before any pattern reports the pattern as missing.
		push_byte(KIND_TEXT, 8'h00, 1'b1);
		// Extreme byte values; the rightmost of two matches wins.
		push_byte(KIND_PATTERN, 8'h00, 1'b0);
		push_byte(KIND_PATTERN, 8'hFF, 1'b1);
		push_byte(KIND_TEXT, 8'h00, 1'b0);
		push_byte(KIND_TEXT, 8'hFF, 1'b0);
		push_byte(KIND_TEXT, 8'h00, 1'b0);
		push_byte(KIND_TEXT, 8'hFF, 1'b1);
		// A text shorter than the pattern is not found but still ok.
		push_byte(KIND_TEXT, 8'h00, 1'b1);
		// A pattern byte after a complete pattern replaces it.
		push_byte(KIND_PATTERN, 8'hA5, 1'b1);
		push_byte(KIND_TEXT, 8'h5A, 1'b0);
		push_byte(KIND_TEXT, 8'hA5, 1'b1);
		// A pattern byte in the middle of a text discards that text without a result.
		push_byte(KIND_TEXT, 8'hA5, 1'b0);
		push_byte(KIND_PATTERN, 8'h3C, 1'b1);
		push_byte(KIND_TEXT, 8'h3C, 1'b1);
		// An unfinished pattern makes the text report a missing pattern.
		push_byte(KIND_PATTERN, 8'h11, 1'b0);
		push_byte(KIND_TEXT, 8'h11, 1'b1);
		// The unfinished pattern is extended by the next pattern byte.
		push_byte(KIND_PATTERN, 8'hC3, 1'b1);
		push_byte(KIND_TEXT, 8'h11, 1'b0);
		push_byte(KIND_TEXT, 8'hC3, 1'b0);
		push_byte(KIND_TEXT, 8'h11, 1'b0);
		push_byte(KIND_TEXT, 8'hC3, 1'b1);

		// Pattern size limits, at full rate. A pattern of the largest size matching a text of
		// its own.
		drain_and_pace(0, 0);
		for (int i = 0; i < PATTERN_LIMIT; i++) begin
			pat16.push_back(8'($urandom_range(255, 0)));
			push_byte(KIND_PATTERN, pat16[i], i == PATTERN_LIMIT - 1);
		end
		foreach (pat16[i])
			push_byte(KIND_TEXT, pat16[i], i == PATTERN_LIMIT - 1);
		// One byte too many makes the pattern unusable.
		for (int i = 0; i <= PATTERN_LIMIT; i++)
			push_byte(KIND_PATTERN, 8'($urandom_range(255, 0)), i == PATTERN_LIMIT);
		push_byte(KIND_TEXT, 8'h00, 1'b1);

		// Random sessions under four pacing regimes; each switch waits for the block to drain.
		bytes_sent = 0;
		drain_and_pace(0, 0);
		while (bytes_sent < RANDOM_ITEMS / 4) random_session();
		drain_and_pace(87, 0);
		while (bytes_sent < RANDOM_ITEMS / 2) random_session();
		drain_and_pace(0, 87);
		while (bytes_sent < 3 * RANDOM_ITEMS / 4) random_session();
		drain_and_pace(30, 30);
		while (bytes_sent < RANDOM_ITEMS) random_session();

		// Wait for the last results, then a few more cycles to catch any stray output.
		drain_and_pace(0, 0);
		repeat (8) @(posedge clk);
		if (chk_fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/lso_pkg.sv
hw/rtl/lso_in_if.sv
hw/rtl/lso_out_if.sv
hw/rtl/lso_front.sv
hw/rtl/lso_queue.sv
hw/rtl/lso_back.sv
hw/rtl/last_substring_occurrence.sv
tb/lso_tb_pkg.sv
tb/lso_search_checker.sv
tb/testbench.sv
